@@ src/bdy_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdy_pkg
// Shared types, codes and list-store address helpers for the buddy allocator.
// ----------------------------------------------------------------------------
package bdy_pkg;

    localparam int MAX_ORDER  = 10;
    localparam int NUM_ORD    = MAX_ORDER + 1;
    localparam int ORD_W      = 4;
    localparam int ADDR_W     = MAX_ORDER;
    localparam int SIZE_W     = 11;
    localparam int LEN_W      = MAX_ORDER + 1;
    localparam int LIST_AW    = MAX_ORDER + 1;
    localparam int LIST_DEPTH = 2 << MAX_ORDER;
    localparam int POOL_UNITS = 1 << MAX_ORDER;
    localparam int RESET_ORDER = (10 > MAX_ORDER) ? MAX_ORDER : 10;

    localparam logic       OP_ALLOC   = 1'b0;
    localparam logic       OP_FREE    = 1'b1;
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_BADFREE = 2'd2;
    localparam logic       REG_POOL_ORDER = 1'b0;

    typedef logic [ORD_W-1:0]  t_ord;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [LEN_W-1:0]  t_len;

    typedef struct packed {
        logic              op;
        logic [SIZE_W-1:0] request_size;
        t_addr             free_address;
    } t_in_req;

    typedef struct packed {
        logic [1:0] status;
        t_addr      block_start;
        t_addr      block_end;
        logic       merged;
        t_addr      merged_start;
    } t_out_rsp;

    typedef struct packed {
        logic fail;
        t_ord x;
        t_ord i;
    } t_srch;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ALOC_SRCH,
        S_ALOC_POP,
        S_ALOC_SPLIT,
        S_FREE_LOOK,
        S_FREE_SCAN,
        S_FREE_PUSH,
        S_RESP
    } t_state;

    // start of the region that holds the list of order k
    function automatic logic [LIST_AW-1:0] list_base(input t_ord k);
        logic [LIST_AW:0] full;
        logic [LIST_AW:0] span;
        full = (LIST_AW+1)'(1) << LIST_AW;
        span = (LIST_AW+1)'(2) << (MAX_ORDER - int'(k));
        return LIST_AW'(full - span);
    endfunction

    // physical address of ring position pos in the list of order k
    function automatic logic [LIST_AW-1:0] list_addr(input t_ord k, input t_addr pos);
        t_addr mask;
        mask = ADDR_W'((1 << (MAX_ORDER - int'(k))) - 1);
        return list_base(k) + LIST_AW'(pos & mask);
    endfunction

endpackage

@@ src/bdy_order_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdy_order_search
// Rounds a request size up to an order and finds the first nonempty list.
// ----------------------------------------------------------------------------
module bdy_order_search import bdy_pkg::*; (
    input  logic [SIZE_W-1:0] i_size,
    input  t_ord              i_pool_order,
    input  t_len              i_len [NUM_ORD],
    output t_srch             o_srch
);

    logic [SIZE_W-1:0] s_m1;
    t_ord              x;
    t_ord              sel;
    logic              hit;

    always_comb begin
        s_m1 = (i_size == '0) ? '0 : i_size - SIZE_W'(1);
        x = '0;
        for (int b = 0; b < SIZE_W; b++) begin
            if (s_m1[b]) x = ORD_W'(b + 1);
        end
        sel = '0;
        hit = 1'b0;
        for (int k = NUM_ORD - 1; k >= 0; k--) begin
            if (ORD_W'(k) >= x && ORD_W'(k) <= i_pool_order && i_len[k] != '0) begin
                sel = ORD_W'(k);
                hit = 1'b1;
            end
        end
        o_srch.fail = (x > i_pool_order) || !hit;
        o_srch.x    = x;
        o_srch.i    = sel;
    end

endmodule

@@ src/buddy_allocator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_allocator_core
// Buddy allocator with per-order ring free lists and a live-allocation map.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | i_in_valid/o_in_ready | i_in_req  (t_in_req)
//  out     | output    | o_out_valid/i_out_ready | o_out_rsp (t_out_rsp)
//  cfg     | input     | psel/penable/pwrite   | paddr, pwdata, prdata
//
// Allocate: order search, pop from the chosen list, one split step per level.
// Free: live-map look-up, then, unless the freed order's list is empty, a scan of
// it for the buddy, one entry at a time, set by the single read port of the list
// RAM. Requests are taken in the idle state. Reset and every pool_order write run
// a clear of the live map; no request is taken meanwhile. A stalled output holds
// the result; the next request is taken, but its result waits in S_RESP.
// ----------------------------------------------------------------------------
module buddy_allocator_core import bdy_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_req     i_in_req,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_rsp    o_out_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // memories
    t_addr             list_mem [LIST_DEPTH];
    logic [ORD_W:0]    live_mem [POOL_UNITS];
    t_addr             r_lm_rd;
    logic [ORD_W:0]    r_lv_rd;

    logic              lm_we;
    logic [LIST_AW-1:0] lm_waddr, lm_raddr;
    t_addr             lm_wdata;
    logic              lv_we;
    t_addr             lv_waddr, lv_raddr;
    logic [ORD_W:0]    lv_wdata;

    // control
    t_state   r_state, n_state;
    t_ord     r_pool_order, n_pool_order;
    t_len     r_len [NUM_ORD];
    t_len     n_len [NUM_ORD];
    t_addr    r_head [NUM_ORD];
    t_addr    n_head [NUM_ORD];
    t_addr    r_clr_cnt, n_clr_cnt;
    logic     r_out_valid, n_out_valid;
    t_len     r_rd_idx, n_rd_idx;
    logic     r_cmp_vld, n_cmp_vld;
    logic     r_found, n_found;

    // payload
    t_in_req  r_req, n_req;
    t_ord     r_x, n_x;
    t_ord     r_i, n_i;
    t_ord     r_n, n_n;
    t_addr    r_a, n_a;
    logic [ADDR_W:0] r_buddy, n_buddy;
    logic     r_odd, n_odd;
    t_len     r_cmp_idx, n_cmp_idx;
    t_out_rsp r_rsp, n_rsp;
    t_out_rsp r_out_data, n_out_data;

    t_srch    srch;
    logic     cfg_wr;
    t_ord     cfg_order;
    t_ord     k_dn, n_up;
    t_addr    sz;
    t_len     cur_len;
    t_ord     lv_n;
    logic [ADDR_W:0] fa_ext;
    logic [ADDR_W:0] blk_sz;
    logic     lv_odd;

    bdy_order_search u_search (
        .i_size       (r_req.request_size),
        .i_pool_order (r_pool_order),
        .i_len        (r_len),
        .o_srch       (srch)
    );

    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == REG_POOL_ORDER) ? {28'd0, r_pool_order} : 32'd0;
    assign cfg_wr      = psel && penable && pwrite && (paddr[2] == REG_POOL_ORDER);
    assign cfg_order   = (pwdata[3:0] > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : pwdata[3:0];
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_data;

    always_comb begin
        n_state      = r_state;
        n_pool_order = r_pool_order;
        n_len        = r_len;
        n_head       = r_head;
        n_clr_cnt    = r_clr_cnt;
        n_out_valid  = r_out_valid;
        n_rd_idx     = r_rd_idx;
        n_cmp_vld    = 1'b0;
        n_found      = r_found;
        n_req        = r_req;
        n_x          = r_x;
        n_i          = r_i;
        n_n          = r_n;
        n_a          = r_a;
        n_buddy      = r_buddy;
        n_odd        = r_odd;
        n_cmp_idx    = r_cmp_idx;
        n_rsp        = r_rsp;
        n_out_data   = r_out_data;
        lm_we        = 1'b0;
        lm_waddr     = '0;
        lm_wdata     = '0;
        lm_raddr     = '0;
        lv_we        = 1'b0;
        lv_waddr     = '0;
        lv_wdata     = '0;
        lv_raddr     = i_in_req.free_address;
        k_dn         = r_i - ORD_W'(1);
        n_up         = r_n + ORD_W'(1);
        sz           = ADDR_W'(1 << r_n);
        cur_len      = r_len[r_n];
        // block order may equal the address width, so test the bit one wider
        lv_n         = r_lv_rd[ORD_W-1:0];
        fa_ext       = {1'b0, r_req.free_address};
        blk_sz       = (ADDR_W+1)'(1) << lv_n;
        lv_odd       = |(fa_ext & blk_sz);

        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;

        case (r_state)
            S_CLEAR: begin
                lv_we    = 1'b1;
                lv_waddr = r_clr_cnt;
                if (r_clr_cnt == '0) begin
                    // the whole pool as one free block
                    lm_we    = 1'b1;
                    lm_waddr = list_addr(r_pool_order, '0);
                end
                n_clr_cnt = r_clr_cnt + ADDR_W'(1);
                if (r_clr_cnt == '1) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_req;
                    n_state = (i_in_req.op == OP_ALLOC) ? S_ALOC_SRCH : S_FREE_LOOK;
                end
            end
            S_ALOC_SRCH: begin
                n_x = srch.x;
                n_i = srch.i;
                if (srch.fail) begin
                    n_rsp        = '0;
                    n_rsp.status = ST_NOSPACE;
                    n_state      = S_RESP;
                end else begin
                    lm_raddr          = list_addr(srch.i, r_head[srch.i]);
                    n_head[srch.i]    = r_head[srch.i] + ADDR_W'(1);
                    n_len[srch.i]     = r_len[srch.i] - LEN_W'(1);
                    n_state           = S_ALOC_POP;
                end
            end
            S_ALOC_POP: begin
                n_a     = r_lm_rd;
                n_state = S_ALOC_SPLIT;
            end
            S_ALOC_SPLIT: begin
                if (r_i == r_x) begin
                    lv_we    = 1'b1;
                    lv_waddr = r_a;
                    lv_wdata = {1'b1, r_x};
                    n_rsp              = '0;
                    n_rsp.status       = ST_OK;
                    n_rsp.block_start  = r_a;
                    n_rsp.block_end    = r_a + ADDR_W'((1 << r_x) - 1);
                    n_state            = S_RESP;
                end else begin
                    // lower lists are empty here: upper half becomes their only entry
                    lm_we       = 1'b1;
                    lm_waddr    = list_addr(k_dn, r_head[k_dn] + r_len[k_dn][ADDR_W-1:0]);
                    lm_wdata    = r_a + ADDR_W'(1 << k_dn);
                    n_len[k_dn] = r_len[k_dn] + LEN_W'(1);
                    n_i         = k_dn;
                end
            end
            S_FREE_LOOK: begin
                if (!r_lv_rd[ORD_W]) begin
                    n_rsp        = '0;
                    n_rsp.status = ST_BADFREE;
                    n_state      = S_RESP;
                end else begin
                    n_n       = lv_n;
                    n_a       = r_req.free_address;
                    n_odd     = lv_odd;
                    n_buddy   = lv_odd ? fa_ext - blk_sz : fa_ext + blk_sz;
                    n_rd_idx  = '0;
                    n_found   = 1'b0;
                    lv_we     = 1'b1;
                    lv_waddr  = r_req.free_address;
                    lv_wdata  = {1'b0, lv_n};
                    n_state   = (r_len[lv_n] == '0) ? S_FREE_PUSH : S_FREE_SCAN;
                end
            end
            S_FREE_SCAN: begin
                if (r_rd_idx < cur_len) begin
                    lm_raddr  = list_addr(r_n, r_head[r_n] + r_rd_idx[ADDR_W-1:0]);
                    n_rd_idx  = r_rd_idx + LEN_W'(1);
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_rd_idx;
                end
                if (r_cmp_vld) begin
                    if (r_found) begin
                        // close the gap left by the buddy
                        lm_we    = 1'b1;
                        lm_waddr = list_addr(r_n, r_head[r_n] + r_cmp_idx[ADDR_W-1:0]
                                             - ADDR_W'(1));
                        lm_wdata = r_lm_rd;
                    end else if ({1'b0, r_lm_rd} == r_buddy) begin
                        n_found = 1'b1;
                    end
                end
                if (r_rd_idx == cur_len) n_state = S_FREE_PUSH;
            end
            S_FREE_PUSH: begin
                n_rsp             = '0;
                n_rsp.status      = ST_OK;
                n_rsp.block_start = r_a;
                n_rsp.block_end   = r_a + sz - ADDR_W'(1);
                if (r_found) begin
                    n_len[r_n]         = cur_len - LEN_W'(1);
                    n_rsp.merged       = 1'b1;
                    n_rsp.merged_start = r_odd ? r_buddy[ADDR_W-1:0] : r_a;
                    if (r_n < ORD_W'(MAX_ORDER)) begin
                        lm_we       = 1'b1;
                        lm_waddr    = list_addr(n_up, r_head[n_up]
                                                + r_len[n_up][ADDR_W-1:0]);
                        lm_wdata    = r_odd ? r_buddy[ADDR_W-1:0] : r_a;
                        n_len[n_up] = r_len[n_up] + LEN_W'(1);
                    end
                end else begin
                    lm_we      = 1'b1;
                    lm_waddr   = list_addr(r_n, r_head[r_n] + cur_len[ADDR_W-1:0]);
                    lm_wdata   = r_a;
                    n_len[r_n] = cur_len + LEN_W'(1);
                end
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_data  = r_rsp;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase

        if (cfg_wr) begin
            n_pool_order = cfg_order;
            for (int k = 0; k < NUM_ORD; k++) begin
                n_len[k]  = '0;
                n_head[k] = '0;
            end
            n_len[cfg_order] = LEN_W'(1);
            n_clr_cnt        = '0;
            n_state          = S_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_pool_order <= ORD_W'(RESET_ORDER);
            for (int k = 0; k < NUM_ORD; k++) begin
                r_len[k]  <= (k == RESET_ORDER) ? LEN_W'(1) : '0;
                r_head[k] <= '0;
            end
            r_clr_cnt    <= '0;
            r_out_valid  <= 1'b0;
            r_rd_idx     <= '0;
            r_cmp_vld    <= 1'b0;
            r_found      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pool_order <= n_pool_order;
            r_len        <= n_len;
            r_head       <= n_head;
            r_clr_cnt    <= n_clr_cnt;
            r_out_valid  <= n_out_valid;
            r_rd_idx     <= n_rd_idx;
            r_cmp_vld    <= n_cmp_vld;
            r_found      <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_x        <= n_x;
        r_i        <= n_i;
        r_n        <= n_n;
        r_a        <= n_a;
        r_buddy    <= n_buddy;
        r_odd      <= n_odd;
        r_cmp_idx  <= n_cmp_idx;
        r_rsp      <= n_rsp;
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (lm_we) list_mem[lm_waddr] <= lm_wdata;
        r_lm_rd <= list_mem[lm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (lv_we) live_mem[lv_waddr] <= lv_wdata;
        r_lv_rd <= live_mem[lv_raddr];
    end

    // at most one free block spans the whole pool
    a_pool_list_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len[r_pool_order] <= LEN_W'(1))
        else $error("more than one pool-sized free block");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FREE_SCAN) |-> (r_rd_idx <= r_len[r_n]))
        else $error("free-list scan ran past list length");

    a_cfg_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> (r_state == S_CLEAR && r_clr_cnt == '0))
        else $error("pool_order write did not restart the clear pass");

    a_rsp_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_RESP))
        else $error("result presented outside the response state");

endmodule
